// ===== sv/json_string_unescaper_macros.svh =====
// assertion macros shared by the json string unescaper rtl
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jsu_pkg.sv =====
// types, character codes and helper functions of the json string unescaper
package jsu_pkg;

    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_CHAR_U    = 8'h75;
    localparam logic [7:0] C_CHAR_B    = 8'h62;
    localparam logic [7:0] C_CHAR_F    = 8'h66;
    localparam logic [7:0] C_CHAR_N    = 8'h6E;
    localparam logic [7:0] C_CHAR_R    = 8'h72;
    localparam logic [7:0] C_CHAR_T    = 8'h74;

    localparam logic [7:0] C_CTRL_BS   = 8'h08;
    localparam logic [7:0] C_CTRL_FF   = 8'h0C;
    localparam logic [7:0] C_CTRL_LF   = 8'h0A;
    localparam logic [7:0] C_CTRL_CR   = 8'h0D;
    localparam logic [7:0] C_CTRL_TAB  = 8'h09;

    // hex digit positions inside a u escape: 1 .. HEX_FINAL, 0 when outside
    localparam logic [2:0] HEX_IDLE    = 3'd0;
    localparam logic [2:0] HEX_FIRST   = 3'd1;
    localparam logic [2:0] HEX_FINAL   = 3'd4;

    typedef struct packed {
        logic        in_escape;
        logic [2:0]  hex_count;
        logic [15:0] code_accum;
        logic        discarding;
    } t_esc_state;

    localparam t_esc_state ESC_STATE_RESET = '{
        in_escape:  1'b0,
        hex_count:  HEX_IDLE,
        code_accum: 16'h0000,
        discarding: 1'b0
    };

    // results caused by one input byte
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            last;
        logic            bvalid;
        logic            err;
    } t_burst;

    // msb set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'b10000;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    // one code unit as one to three utf-8 bytes
    function automatic t_burst utf8_encode(input logic [15:0] cu);
        t_burst b;
        b        = '0;
        b.bvalid = 1'b1;
        if (cu < 16'h0080) begin
            b.cnt      = 2'd1;
            b.bytes[0] = cu[7:0];
        end else if (cu < 16'h0800) begin
            b.cnt      = 2'd2;
            b.bytes[0] = {3'b110, cu[10:6]};
            b.bytes[1] = {2'b10, cu[5:0]};
        end else begin
            b.cnt      = 2'd3;
            b.bytes[0] = {4'b1110, cu[15:12]};
            b.bytes[1] = {2'b10, cu[11:6]};
            b.bytes[2] = {2'b10, cu[5:0]};
        end
        return b;
    endfunction

endpackage

// ===== sv/jsu_decode.sv =====
// next escape state and result burst for one input byte
module jsu_decode
    import jsu_pkg::*;
(
    input  t_esc_state i_st,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_esc_state o_st,
    output t_burst     o_burst
);

    logic [4:0]  hv;
    logic [15:0] accum_shift;
    t_burst      plain;
    t_burst      bad;

    assign hv          = hex_value(i_byte);
    assign accum_shift = {i_st.code_accum[11:0], hv[3:0]};

    always_comb begin
        plain          = '0;
        plain.cnt      = 2'd1;
        plain.bvalid   = 1'b1;
        plain.bytes[0] = i_byte;
        bad            = '0;
        bad.cnt        = 2'd1;
        bad.last       = 1'b1;
        bad.err        = 1'b1;
    end

    always_comb begin
        o_st    = i_st;
        o_burst = '0;
        if (i_st.discarding) begin
            if (i_last) begin
                o_st = ESC_STATE_RESET;
            end
        end else if (i_st.hex_count >= HEX_FIRST && i_st.hex_count <= HEX_FINAL) begin
            if (hv[4]) begin
                // bad hex digit: report once, skip the rest of the string
                o_st            = ESC_STATE_RESET;
                o_st.discarding = !i_last;
                o_burst         = bad;
            end else if (i_st.hex_count == HEX_FINAL) begin
                o_burst         = utf8_encode(accum_shift);
                o_st.hex_count  = HEX_IDLE;
                o_st.code_accum = '0;
            end else if (i_last) begin
                o_st    = ESC_STATE_RESET;
                o_burst = bad;
            end else begin
                o_st.hex_count  = i_st.hex_count + 3'd1;
                o_st.code_accum = accum_shift;
            end
        end else if (i_st.in_escape) begin
            o_st.in_escape = 1'b0;
            o_burst        = plain;
            unique case (i_byte)
                C_CHAR_B: o_burst.bytes[0] = C_CTRL_BS;
                C_CHAR_F: o_burst.bytes[0] = C_CTRL_FF;
                C_CHAR_N: o_burst.bytes[0] = C_CTRL_LF;
                C_CHAR_R: o_burst.bytes[0] = C_CTRL_CR;
                C_CHAR_T: o_burst.bytes[0] = C_CTRL_TAB;
                C_CHAR_U: begin
                    o_burst         = '0;
                    o_st.hex_count  = HEX_FIRST;
                    o_st.code_accum = '0;
                    if (i_last) begin
                        o_burst = bad;
                    end
                end
                default: o_burst.bytes[0] = i_byte;
            endcase
        end else begin
            o_st.hex_count = HEX_IDLE;
            if (i_byte == C_BACKSLASH) begin
                o_st.in_escape = 1'b1;
            end else begin
                o_burst = plain;
            end
        end

        // end of string (not discarding): clear escape state, give a bare end marker if nothing else
        if (i_last && !i_st.discarding) begin
            o_st.in_escape  = 1'b0;
            o_st.hex_count  = HEX_IDLE;
            o_st.code_accum = '0;
            o_burst.last    = 1'b1;
            if (o_burst.cnt == 2'd0) begin
                o_burst.cnt    = 2'd1;
                o_burst.bytes  = '0;
                o_burst.bvalid = 1'b0;
                o_burst.err    = 1'b0;
            end
        end
    end

endmodule

// ===== sv/json_string_unescaper.sv =====
// top level of the json string unescaper
//
// input channel: one raw byte of an escaped json string body per transaction
// (i_in_byte, i_in_last marking the final byte), handshake i_in_valid / o_in_stall.
// output channel: one result per transaction (o_out_byte, o_byte_valid,
// o_out_last, o_error), handshake o_out_valid / i_out_stall.
// a byte taken into the input register is decoded out of it, and its first result
// is registered in the result register, from which it can be taken.
// throughput: one input byte per cycle while every byte gives at most one
// result and i_out_stall is low; a completed u escape gives up to three utf-8 bytes,
// sent one per cycle while i_out_stall is low, and the input register holds the next
// byte (o_in_stall high) until the last of them leaves the result register.
// bytes that give no result (backslash, hex digits, discarded bytes) still pass
// one per cycle. an error, or a string end with nothing to send outside a discarded
// string, gives a single result with o_byte_valid low and o_out_last high.
// reset (synchronous, i_rst_n low) empties both registers and clears the escape
// state. while i_out_stall is high the result fields hold and, once the input
// register is occupied, o_in_stall rises to hold off the sender.
`include "json_string_unescaper_macros.svh"

module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_out_last,
    output logic       o_error
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // escape state and result burst register
    t_esc_state r_st;
    t_esc_state n_st;
    t_burst     r_burst;
    t_burst     n_burst;
    logic [1:0] r_idx;

    logic in_take;
    logic out_take;
    logic at_final;
    logic burst_free;
    logic move;

    jsu_decode u_decode (
        .i_st    (r_st),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_st    (n_st),
        .o_burst (n_burst)
    );

    // handshake control
    assign at_final    = (r_idx == r_burst.cnt - 2'd1);
    assign out_take    = o_out_valid && !i_out_stall;
    assign burst_free  = (r_burst.cnt == 2'd0) || (out_take && at_final);
    assign move        = r_in_vld && burst_free;
    assign o_in_stall  = r_in_vld && !move;
    assign in_take     = i_in_valid && !o_in_stall;

    // result fields straight from the burst register
    assign o_out_valid  = (r_burst.cnt != 2'd0);
    assign o_out_byte   = r_burst.bytes[r_idx];
    assign o_byte_valid = r_burst.bvalid;
    assign o_error      = r_burst.err;
    assign o_out_last   = r_burst.last && at_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // escape state advances as a byte leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ESC_STATE_RESET;
        end else if (move) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= '0;
            r_idx   <= 2'd0;
        end else if (move) begin
            r_burst <= n_burst;
            r_idx   <= 2'd0;
        end else if (out_take && at_final) begin
            r_burst.cnt <= 2'd0;
            r_idx       <= 2'd0;
        end else if (out_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    `JSU_ASSERT_IMPL(a_idx_in_burst, r_burst.cnt != 2'd0, r_idx < r_burst.cnt, "burst index beyond count")
    `JSU_ASSERT_IMPL(a_err_is_marker, o_out_valid && o_error, !o_byte_valid && o_out_last && r_burst.cnt == 2'd1, "error result is not a bare end marker")
    `JSU_ASSERT_IMPL(a_discard_clean, r_st.discarding, !r_st.in_escape && r_st.hex_count == HEX_IDLE, "escape state left while discarding")
    `JSU_ASSERT_IMPL(a_hex_range, 1'b1, r_st.hex_count <= HEX_FINAL, "hex digit count out of range")
    `JSU_ASSERT_NEXT(a_last_clears, move && r_in_last, !r_st.in_escape && r_st.hex_count == HEX_IDLE && !r_st.discarding, "string end left escape state behind")

endmodule
